/* rtl/core/pds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent-decode stream package
// Shared types, character codes and the hex digit helper for the decoder.
// ----------------------------------------------------------------------------
package pds_pkg;

   localparam logic [7:0] CHAR_PCT    = 8'h25;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [4:0] DIGIT_TEN   = 5'd10;
   localparam logic [4:0] DIGIT_NONE  = 5'd16;

   // Escape phase codes.
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_PCT   = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;

   // Bundle queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int BUNDLE_WORDS = 3;

   // The words one input byte gives rise to, in order.
   typedef struct packed {
      logic [BUNDLE_WORDS-1:0][7:0] chars;
      logic [1:0]                   count;
      logic                         last;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } push_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } head_type;

   // Hex digit value, or DIGIT_NONE when the byte is not a hex digit.
   function automatic logic [4:0] digit_value(input logic [7:0] ch);
      logic [4:0] result;
      result = DIGIT_NONE;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         result = 5'(ch - CHAR_ZERO);
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) begin
         result = DIGIT_TEN + 5'(ch - CHAR_LOWER_A);
      end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
         result = DIGIT_TEN + 5'(ch - CHAR_UPPER_A);
      end
      return result;
   endfunction

endpackage

/* rtl/core/pds_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent-decode stream channels
// Valid/ready channels for the input bytes and the decoded result words.
// ----------------------------------------------------------------------------
interface pds_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       is_final;

   modport source (output valid, output in_char, output is_final, input ready);
   modport sink (input valid, input in_char, input is_final, output ready);
endinterface

interface pds_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_end;
   logic       string_end;

   modport source (output valid, output out_char, output run_end, output string_end,
                   input ready);
   modport sink (input valid, input out_char, input run_end, input string_end,
                 output ready);
endinterface

/* rtl/core/pds_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent-decode front end
// Accepts one byte a cycle while the queue has room, tracks the escape state
// and emits a bundle of up to three result words per byte that produces any.
// ----------------------------------------------------------------------------
module pds_front
   import pds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pds_req_if.sink       req_chan,
   input  logic          queue_full,
   output push_type      push
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic [4:0] char_digit;
   logic [4:0] held_digit_val;
   logic       char_hex;
   logic [7:0] decoded;
   logic [BUNDLE_WORDS-1:0][7:0] chars;
   logic [1:0] count;
   logic [1:0] next_phase;
   logic [7:0] next_held;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;

   assign char_digit     = digit_value(req_chan.in_char);
   assign char_hex       = !char_digit[4];
   assign held_digit_val = digit_value(held_ff);
   assign decoded        = {held_digit_val[3:0], char_digit[3:0]};

   always_comb begin
      chars      = '0;
      count      = 2'd0;
      next_phase = PHASE_IDLE;
      next_held  = 8'd0;
      case (phase_ff)
         PHASE_PCT: begin
            if (char_hex) begin
               next_phase = PHASE_DIGIT;
               next_held  = req_chan.in_char;
            end else begin
               chars[0] = CHAR_PCT;
               if (req_chan.in_char == CHAR_PCT) begin
                  next_phase = PHASE_PCT;
                  count      = 2'd1;
               end else begin
                  chars[1] = req_chan.in_char;
                  count    = 2'd2;
               end
            end
         end
         PHASE_DIGIT: begin
            if (char_hex) begin
               if (decoded != 8'd0) begin
                  chars[0] = decoded;
                  count    = 2'd1;
               end else begin
                  // A zero escape is passed through as its three source bytes.
                  chars[0] = CHAR_PCT;
                  chars[1] = held_ff;
                  chars[2] = req_chan.in_char;
                  count    = 2'd3;
               end
            end else begin
               chars[0] = CHAR_PCT;
               chars[1] = held_ff;
               if (req_chan.in_char == CHAR_PCT) begin
                  next_phase = PHASE_PCT;
                  count      = 2'd2;
               end else begin
                  chars[2] = req_chan.in_char;
                  count    = 2'd3;
               end
            end
         end
         default: begin
            if (req_chan.in_char == CHAR_PCT) begin
               next_phase = PHASE_PCT;
            end else begin
               chars[0] = req_chan.in_char;
               count    = 2'd1;
            end
         end
      endcase

      // At the end of the string a pending escape is flushed as it stands.
      if (req_chan.is_final) begin
         if (next_phase == PHASE_PCT) begin
            case (count)
               2'd0:    chars[0] = CHAR_PCT;
               2'd1:    chars[1] = CHAR_PCT;
               default: chars[2] = CHAR_PCT;
            endcase
            count = count + 2'd1;
         end else if (next_phase == PHASE_DIGIT) begin
            // This phase is only entered from an empty bundle.
            chars[0] = CHAR_PCT;
            chars[1] = next_held;
            count    = 2'd2;
         end
         next_phase = PHASE_IDLE;
         next_held  = 8'd0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      if (accept) begin
         phase_in = next_phase;
         held_in  = next_held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         held_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   assign push.valid         = accept && (count != 2'd0);
   assign push.bundle.chars  = chars;
   assign push.bundle.count  = count;
   assign push.bundle.last   = req_chan.is_final;

endmodule

/* rtl/core/pds_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent-decode bundle queue
// A short register queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module pds_queue
   import pds_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   bundle_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid  = (count_ff != '0);
   assign head.bundle = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/pds_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent-decode back end
// Serialises the head bundle into result words, one per cycle while the
// receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module pds_back
   import pds_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   pds_rsp_if.source rsp_chan
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       run_end_ff, run_end_in;
   logic       string_end_ff, string_end_in;
   logic [1:0] index_ff, index_in;
   logic       load;
   logic       last_word;

   assign load      = head.valid && (!valid_ff || rsp_chan.ready);
   assign last_word = (index_ff == head.bundle.count - 2'd1);
   assign pop       = load && last_word;

   always_comb begin
      valid_in      = valid_ff && !rsp_chan.ready;
      char_in       = char_ff;
      run_end_in    = run_end_ff;
      string_end_in = string_end_ff;
      index_in      = index_ff;
      if (load) begin
         valid_in      = 1'b1;
         char_in       = head.bundle.chars[index_ff];
         run_end_in    = last_word;
         string_end_in = last_word && head.bundle.last;
         index_in      = last_word ? 2'd0 : index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      run_end_ff    <= run_end_in;
      string_end_ff <= string_end_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.out_char   = char_ff;
   assign rsp_chan.run_end    = run_end_ff;
   assign rsp_chan.string_end = string_end_ff;

endmodule

/* rtl/core/percent_decode_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent-decode stream
// Streaming URI percent-escape decoder with a flag on the final byte.
// ----------------------------------------------------------------------------
// The block accepts one input byte per cycle as long as its four-entry bundle
// queue has room, and each byte that produces output places one bundle of one
// to three words in that queue. The back end sends one result word per cycle
// while the receiver is ready, through a registered output; since decoding
// never lengthens a string, the queue absorbs the bursts of bytes that yield
// more than one word and the sustained rate stays at one byte per cycle. The
// first result word of a byte passes through the bundle queue and then the
// output register before it is presented. run_end marks the last word caused
// by a byte, and string_end the last word of the decoded string.
module percent_decode_stream
   import pds_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   pds_req_if.sink   req_chan,
   pds_rsp_if.source rsp_chan
);

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   pds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   pds_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   pds_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/core/pds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent-decode stream checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pds_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_run_end,
   input logic       rsp_string_end
);

   // The end of the string is always the last word of its byte.
   a_string_end_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_end)
      else $error("string_end without run_end");

   // The output register is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word shown after reset");

   // The queue is empty after reset, so input is taken at once.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

   // A stalled word holds its value.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_run_end) && $stable(rsp_string_end))
      else $error("stalled result word changed");

endmodule

bind percent_decode_stream pds_checker u_pds_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_char   (rsp_chan.out_char),
   .rsp_run_end    (rsp_chan.run_end),
   .rsp_string_end (rsp_chan.string_end)
);

/* tb/pds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent-decode stream checker
// Watches both channels, decodes every accepted input byte on its own and
// compares each accepted result word with the oldest decoded word waiting.
// ----------------------------------------------------------------------------
module tb_pds_checker
   import pds_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pds_req_if   req_mon,
   pds_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   words_seen
);

   typedef struct packed {
      logic [7:0] ch;
      logic       run_end;
      logic       string_end;
   } dec_word_type;

   dec_word_type decoded_q[$];
   dec_word_type step_q[$];
   logic [1:0]   esc_phase;
   logic [7:0]   esc_digit;

   // Nibble value of a hex digit, 16 for any other byte.
   function automatic int hex_nibble(input logic [7:0] c);
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         return int'(c) - int'(CHAR_ZERO);
      end
      if (c inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
         return int'(c) - int'(CHAR_LOWER_A) + 10;
      end
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         return int'(c) - int'(CHAR_UPPER_A) + 10;
      end
      return 16;
   endfunction

   function automatic void emit(input logic [7:0] c);
      step_q.push_back('{ch: c, run_end: 1'b0, string_end: 1'b0});
   endfunction

   function automatic void plain_char(input logic [7:0] c);
      if (c == CHAR_PCT) begin
         esc_phase = PHASE_PCT;
      end else begin
         emit(c);
      end
   endfunction

   task automatic decode_byte(input logic [7:0] c, input logic last);
      logic [1:0] phase;
      int         v;
      int         h;
      logic [7:0] value;
      phase = esc_phase;
      v = hex_nibble(c);
      esc_phase = PHASE_IDLE;
      step_q.delete();
      case (phase)
         PHASE_PCT: begin
            if (v < 16) begin
               esc_digit = c;
               esc_phase = PHASE_DIGIT;
            end else begin
               emit(CHAR_PCT);
               plain_char(c);
            end
         end
         PHASE_DIGIT: begin
            h = hex_nibble(esc_digit);
            if (h > 15) h = 0;
            if (v < 16) begin
               value = {h[3:0], v[3:0]};
               // An escape of value zero is passed through as it stands.
               if (value != 8'd0) begin
                  emit(value);
               end else begin
                  emit(CHAR_PCT);
                  emit(esc_digit);
                  emit(c);
               end
            end else begin
               emit(CHAR_PCT);
               emit(esc_digit);
               plain_char(c);
            end
            if (esc_phase != PHASE_DIGIT) esc_digit = 8'd0;
         end
         default: begin
            plain_char(c);
         end
      endcase
      if (last) begin
         if (esc_phase == PHASE_PCT) begin
            emit(CHAR_PCT);
         end else if (esc_phase == PHASE_DIGIT) begin
            emit(CHAR_PCT);
            emit(esc_digit);
         end
         esc_phase = PHASE_IDLE;
         esc_digit = 8'd0;
      end
      if (step_q.size() > 0) begin
         step_q[step_q.size()-1].run_end = 1'b1;
         step_q[step_q.size()-1].string_end = last;
      end
      foreach (step_q[i]) decoded_q.push_back(step_q[i]);
   endtask

   task automatic report(input string msg);
      if (fail_count < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      dec_word_type want;
      if (reset) begin
         decoded_q.delete();
         esc_phase = PHASE_IDLE;
         esc_digit = 8'd0;
         fail_count = 0;
         pending = 0;
         words_seen = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (decoded_q.size() == 0) begin
               report($sformatf("word %02h with nothing expected", rsp_mon.out_char));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_mon.out_char !== want.ch) begin
                  report($sformatf("word %0d out_char %02h, expected %02h",
                                   words_seen, rsp_mon.out_char, want.ch));
               end
               if (rsp_mon.run_end !== want.run_end) begin
                  report($sformatf("word %0d run_end %b, expected %b",
                                   words_seen, rsp_mon.run_end, want.run_end));
               end
               if (rsp_mon.string_end !== want.string_end) begin
                  report($sformatf("word %0d string_end %b, expected %b",
                                   words_seen, rsp_mon.string_end, want.string_end));
               end
            end
            words_seen++;
         end
         if (req_mon.valid && req_mon.ready) begin
            decode_byte(req_mon.in_char, req_mon.is_final);
         end
         pending = decoded_q.size();
      end
   end

endmodule

/* tb/tb_percent_decode_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent-decode stream testbench
// Drives directed and random strings into the decoder with random idling on
// both channels; a checker beside the block predicts and compares the words.
// ----------------------------------------------------------------------------
module tb_percent_decode_stream;
   import pds_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BYTES = 155;
   localparam int CALM_TAIL = 30;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } src_byte_type;

   logic         clock;
   logic         reset;
   src_byte_type stream_q[$];
   int           string_count;
   int           stall_cycles;
   int           fail_count;
   int           pending;
   int           words_seen;
   bit           calm;

   pds_req_if req_if ();
   pds_rsp_if rsp_if ();

   percent_decode_stream u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   tb_pds_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .fail_count (fail_count),
      .pending    (pending),
      .words_seen (words_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic add_byte(input logic [7:0] c, input logic last);
      stream_q.push_back('{ch: c, last: last});
      if (last) string_count++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] any_hex();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return CHAR_ZERO + 8'(r);
      if (r < 16) return CHAR_LOWER_A + 8'(r - 10);
      return CHAR_UPPER_A + 8'(r - 16);
   endfunction

   // Mostly well-formed escapes, with broken and cut-short ones mixed in.
   task automatic add_random_string();
      int pieces;
      logic [7:0] run[$];
      pieces = $urandom_range(1, 10);
      for (int p = 0; p < pieces; p++) begin
         case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: begin
               run.push_back(CHAR_PCT);
               run.push_back(any_hex());
               run.push_back(any_hex());
            end
            5: begin
               run.push_back(CHAR_PCT);
               run.push_back(8'($urandom_range(1, 255)));
            end
            6: begin
               run.push_back(CHAR_PCT);
               run.push_back(any_hex());
               run.push_back(8'($urandom_range(1, 255)));
            end
            10: run.push_back(CHAR_PCT);
            11: begin
               run.push_back(CHAR_PCT);
               run.push_back(any_hex());
            end
            default: run.push_back(8'($urandom_range(1, 255)));
         endcase
      end
      foreach (run[i]) add_byte(run[i], i == run.size() - 1);
   endtask

   // Receiver: ready drops in bursts until the calm tail of the run.
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      stall_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int n_directed;
      reset <= 1'b1;
      calm = 1'b0;
      string_count = 0;
      req_if.valid <= 1'b0;
      req_if.in_char <= 8'd0;
      req_if.is_final <= 1'b0;

      // Byte extremes, then a clean escape, broken escapes, a zero escape,
      // strings ending inside an escape and mixed-case digits.
      add_byte(8'h01, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_text("%4a");
      add_text("%g%Fz%%41");
      add_text("%00");
      add_text("%A");
      add_text("%");
      add_text("%fF");
      n_directed = stream_q.size();
      while (stream_q.size() < n_directed + RANDOM_BYTES) add_random_string();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (stream_q[i]) begin
         if (i >= stream_q.size() - CALM_TAIL) calm = 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         req_if.valid <= 1'b1;
         req_if.in_char <= stream_q[i].ch;
         req_if.is_final <= stream_q[i].last;
         do @(posedge clock); while (!req_if.ready);
      end
      req_if.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d input bytes in %0d strings, %0d directed",
               stream_q.size(), string_count, n_directed);
      $display("compared %0d decoded words, %0d mismatches", words_seen, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
